/* rtl/sgpb_pkg.sv */
package sgpb_pkg;

  // Panel geometry and store size
  localparam int unsigned DISP_WIDTH  = 128;
  localparam int unsigned DISP_HEIGHT = 32;
  localparam int unsigned STORE_DEPTH = 512;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  // Glyph cell and page layout
  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned GLYPH_ROWS  = 7;
  localparam int unsigned PAGE_BITS   = 8;

  // Field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned SCALE_W     = 4;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned GX_W        = $clog2(GLYPH_COLS);
  localparam int unsigned GY_W        = $clog2(GLYPH_ROWS);
  localparam int unsigned PBIT_W      = $clog2(PAGE_BITS);
  localparam int unsigned PAGE_W      = COORD_W - PBIT_W;
  // Wide enough for page * DISP_WIDTH + column at any legal geometry
  localparam int unsigned PROD_W      = PAGE_W + COORD_W + 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_DRAW   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_DONE
  } state_e;

endpackage

/* rtl/sgpb_if.sv */
interface sgpb_in_if;
  logic                                valid;
  logic                                ready;
  logic [sgpb_pkg::KIND_W-1:0]         kind;
  logic [sgpb_pkg::BYTE_W-1:0]         glyph_col0;
  logic [sgpb_pkg::BYTE_W-1:0]         glyph_col1;
  logic [sgpb_pkg::BYTE_W-1:0]         glyph_col2;
  logic [sgpb_pkg::BYTE_W-1:0]         glyph_col3;
  logic [sgpb_pkg::BYTE_W-1:0]         glyph_col4;
  logic [sgpb_pkg::COORD_W-1:0]        x_pos;
  logic [sgpb_pkg::COORD_W-1:0]        y_pos;
  logic [sgpb_pkg::SCALE_W-1:0]        scale;
  logic [sgpb_pkg::ADDR_W-1:0]         read_addr;

  modport source (
    output valid, kind, glyph_col0, glyph_col1, glyph_col2, glyph_col3, glyph_col4,
           x_pos, y_pos, scale, read_addr,
    input  ready
  );
  modport sink (
    input  valid, kind, glyph_col0, glyph_col1, glyph_col2, glyph_col3, glyph_col4,
           x_pos, y_pos, scale, read_addr,
    output ready
  );
endinterface

interface sgpb_out_if;
  logic                                valid;
  logic                                ready;
  logic [sgpb_pkg::KIND_W-1:0]         done_kind;
  logic [sgpb_pkg::BYTE_W-1:0]         read_data;

  modport source (
    output valid, done_kind, read_data,
    input  ready
  );
  modport sink (
    input  valid, done_kind, read_data,
    output ready
  );
endinterface

/* rtl/scaled_glyph_page_blitter.sv */
// Scaled glyph blitter over a 1-bit-per-pixel page-layout framebuffer held in
// one single-port synchronous RAM (STORE_DEPTH bytes, each byte 8 vertical
// pixels of one column). Every accepted transaction yields one result
// transaction, in order. After reset the block sweeps the RAM to zero before
// it takes its first transaction. Work per transaction: a read, a kind 3
// transaction and a draw with scale 0 go straight to completion; a clear
// sweeps the whole RAM to zero; a draw with scale s walks 5*s screen columns,
// 7*s pixel rows each, one pixel row per cycle except while a read-modify-
// write runs, and does a read-modify-write each time a page byte of that
// column collects at least one set pixel. The result is registered as the
// block leaves the completion state, which waits until the output register is
// free. The draw cost is set by the one-row-per-cycle walk and the single RAM
// port shared by the read and the write of each byte. A finished result sits
// in an output register, so the next transaction is accepted while it waits.
module scaled_glyph_page_blitter (
  input  logic      clk_i,
  input  logic      rst_ni,
  sgpb_in_if.sink   in_i,
  sgpb_out_if.source out_o
);
  import sgpb_pkg::*;

  // Framebuffer RAM
  byte_t mem [STORE_DEPTH];
  byte_t rd_q;
  logic  mem_we;
  logic  mem_re;
  addr_t mem_addr;
  byte_t mem_wdata;

  // Control state
  state_e state_q, state_d;
  addr_t  clr_cnt_q, clr_cnt_d;
  logic   out_valid_q, out_valid_d;

  // Transaction payload and walk counters
  kind_e                               kind_q, kind_d;
  logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_q, glyph_d;
  logic [COORD_W-1:0]                  y_q, y_d;
  logic [SCALE_W-1:0]                  s_q, s_d;
  logic [COORD_W-1:0]                  px_q, px_d;
  logic [COORD_W-1:0]                  py_q, py_d;
  logic [GX_W-1:0]                     gx_q, gx_d;
  logic [GY_W-1:0]                     gy_q, gy_d;
  logic [SCALE_W-1:0]                  dx_q, dx_d;
  logic [SCALE_W-1:0]                  dy_q, dy_d;
  byte_t                               mask_q, mask_d;
  byte_t                               fmask_q, fmask_d;
  addr_t                               faddr_q, faddr_d;
  logic                                fin_q, fin_d;
  logic [KIND_W-1:0]                   out_kind_q, out_kind_d;
  byte_t                               out_data_q, out_data_d;

  // Walk decode
  logic              in_fire;
  logic              bit_on;
  byte_t             mask_n;
  logic              last_row;
  logic              last_col;
  logic              page_end;
  logic [PROD_W-1:0] byte_addr_full;
  logic              addr_ok;
  logic              flush;
  logic              clr_last;
  logic              out_free;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign in_fire         = in_i.valid && in_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.done_kind = out_kind_q;
  assign out_o.read_data = out_data_q;
  assign out_free        = !out_valid_q || out_o.ready;
  assign clr_last        = (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1));

  // A pixel is drawn only inside the panel; the page byte collects the rows of
  // one column until the page boundary or the bottom of the glyph.
  assign bit_on = glyph_q[gx_q][gy_q]
                  && ({1'b0, px_q} < (COORD_W + 1)'(DISP_WIDTH))
                  && ({1'b0, py_q} < (COORD_W + 1)'(DISP_HEIGHT));
  assign mask_n   = mask_q | (bit_on ? (byte_t'(1) << py_q[PBIT_W-1:0]) : '0);
  assign last_row = (gy_q == GY_W'(GLYPH_ROWS - 1)) && (dy_q == s_q - SCALE_W'(1));
  assign last_col = (gx_q == GX_W'(GLYPH_COLS - 1)) && (dx_q == s_q - SCALE_W'(1));
  assign page_end = (py_q[PBIT_W-1:0] == PBIT_W'(PAGE_BITS - 1)) || last_row;
  assign byte_addr_full = PROD_W'(py_q[COORD_W-1:PBIT_W]) * PROD_W'(DISP_WIDTH)
                          + PROD_W'(px_q);
  assign addr_ok  = (byte_addr_full < PROD_W'(STORE_DEPTH));
  assign flush    = page_end && (mask_n != '0) && addr_ok;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (kind_e'(in_i.kind))
            KIND_CLEAR: state_d = ST_CLEAR;
            KIND_DRAW:  state_d = (in_i.scale == '0) ? ST_DONE : ST_DRAW;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_last) state_d = ST_DONE;
      end
      ST_DRAW: begin
        if (flush) begin
          state_d = ST_RMW_RD;
        end else if (last_row && last_col) begin
          state_d = ST_DONE;
        end
      end
      ST_RMW_RD: state_d = ST_RMW_WR;
      ST_RMW_WR: state_d = fin_q ? ST_DONE : ST_DRAW;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    glyph_d     = glyph_q;
    y_d         = y_q;
    s_d         = s_q;
    px_d        = px_q;
    py_d        = py_q;
    gx_d        = gx_q;
    gy_d        = gy_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    mask_d      = mask_q;
    fmask_d     = fmask_q;
    faddr_d     = faddr_q;
    fin_d       = fin_q;
    out_kind_d  = out_kind_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = faddr_q;
    mem_wdata   = rd_q | fmask_q;

    // Drop the result once the sink takes it
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          kind_d     = kind_e'(in_i.kind);
          glyph_d[0] = in_i.glyph_col0[GLYPH_ROWS-1:0];
          glyph_d[1] = in_i.glyph_col1[GLYPH_ROWS-1:0];
          glyph_d[2] = in_i.glyph_col2[GLYPH_ROWS-1:0];
          glyph_d[3] = in_i.glyph_col3[GLYPH_ROWS-1:0];
          glyph_d[4] = in_i.glyph_col4[GLYPH_ROWS-1:0];
          y_d        = in_i.y_pos;
          s_d        = in_i.scale;
          px_d       = in_i.x_pos;
          py_d       = in_i.y_pos;
          gx_d       = '0;
          gy_d       = '0;
          dx_d       = '0;
          dy_d       = '0;
          mask_d     = '0;
          clr_cnt_d  = '0;
          // Issue the byte read now; data lands in rd_q for the result cycle
          mem_re     = 1'b1;
          mem_addr   = in_i.read_addr;
        end
      end
      ST_DRAW: begin
        mask_d = page_end ? '0 : mask_n;
        if (flush) begin
          fmask_d = mask_n;
          faddr_d = byte_addr_full[ADDR_W-1:0];
          fin_d   = last_row && last_col;
        end
        // Advance one pixel row
        py_d = py_q + COORD_W'(1);
        if (dy_q == s_q - SCALE_W'(1)) begin
          dy_d = '0;
          gy_d = gy_q + GY_W'(1);
        end else begin
          dy_d = dy_q + SCALE_W'(1);
        end
        // Bottom of the glyph: move to the next screen column
        if (last_row) begin
          gy_d = '0;
          dy_d = '0;
          py_d = y_q;
          px_d = px_q + COORD_W'(1);
          if (dx_q == s_q - SCALE_W'(1)) begin
            dx_d = '0;
            gx_d = gx_q + GX_W'(1);
          end else begin
            dx_d = dx_q + SCALE_W'(1);
          end
        end
      end
      ST_RMW_RD: begin
        mem_re = 1'b1;
      end
      ST_RMW_WR: begin
        mem_we = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_data_d  = (kind_q == KIND_READ) ? rd_q : '0;
        end
      end
      default: ;
    endcase
  end

  // Framebuffer RAM: one port, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    glyph_q    <= glyph_d;
    y_q        <= y_d;
    s_q        <= s_d;
    px_q       <= px_d;
    py_q       <= py_d;
    gx_q       <= gx_d;
    gy_q       <= gy_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    mask_q     <= mask_d;
    fmask_q    <= fmask_d;
    faddr_q    <= faddr_d;
    fin_q      <= fin_d;
    out_kind_q <= out_kind_d;
    out_data_q <= out_data_d;
  end

`ifndef NO_ASSERTIONS
  // Every write-back follows its own read of the same byte
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW_WR) |-> ($past(state_q) == ST_RMW_RD))
    else $error("write-back without preceding read");

  // A write-back always carries at least one pixel
  a_wr_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW_WR) |-> (fmask_q != '0))
    else $error("empty write-back mask");

  // An accepted transaction leaves the idle state
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("idle after accepting a transaction");

  // A result appears only from the completion state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside completion");
`endif

endmodule

/* tb/glyph_blit_checker.sv */
`timescale 1ns / 1ps

module glyph_blit_checker
  import sgpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sgpb_in_if          in_mon,
  sgpb_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    kind_e kind;
    byte_t data;
  } blit_result_t;

  byte_t        frame_model [STORE_DEPTH];
  blit_result_t expected_results [$];

  // OR one glyph into the frame model, each set bit grown to an s-by-s square
  function automatic void blit_glyph_model(input logic [GLYPH_COLS*BYTE_W-1:0] glyph,
                                           input byte_t x, input byte_t y,
                                           input logic [SCALE_W-1:0] s);
    int unsigned        col;
    int unsigned        row;
    int unsigned        addr;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    for (int gx = 0; gx < GLYPH_COLS; gx++) begin
      for (int gy = 0; gy < GLYPH_ROWS; gy++) begin
        if (!glyph[gx*BYTE_W + gy]) continue;
        for (int dx = 0; dx < s; dx++) begin
          for (int dy = 0; dy < s; dy++) begin
            // coordinates wrap at 8 bits before clipping
            col = int'(x) + gx * int'(s) + dx;
            row = int'(y) + gy * int'(s) + dy;
            px  = col[COORD_W-1:0];
            py  = row[COORD_W-1:0];
            if (px >= DISP_WIDTH || py >= DISP_HEIGHT) continue;
            addr = (py / PAGE_BITS) * DISP_WIDTH + px;
            if (addr >= STORE_DEPTH) continue;
            frame_model[addr][py % PAGE_BITS] = 1'b1;
          end
        end
      end
    end
  endfunction

  // Apply one transaction to the frame model and return the result it owes
  function automatic blit_result_t blit_predict(input kind_e k,
                                                input logic [GLYPH_COLS*BYTE_W-1:0] glyph,
                                                input byte_t x, input byte_t y,
                                                input logic [SCALE_W-1:0] s,
                                                input addr_t a);
    blit_result_t r;
    r.kind = k;
    r.data = '0;
    case (k)
      KIND_CLEAR: foreach (frame_model[i]) frame_model[i] = '0;
      KIND_DRAW:  blit_glyph_model(glyph, x, y, s);
      KIND_READ:  r.data = frame_model[a];
      default:    ;
    endcase
    return r;
  endfunction

  // Retire the result first: it always belongs to an earlier transaction
  always @(posedge clk_i) begin
    blit_result_t want;
    if (!rst_ni) begin
      foreach (frame_model[i]) frame_model[i] = '0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= REPORT_LIMIT)
            $display("%0t: result with none pending: kind %0d data %02h",
                     $realtime, out_mon.done_kind, out_mon.read_data);
        end else begin
          want = expected_results.pop_front();
          if (out_mon.done_kind !== want.kind || out_mon.read_data !== want.data) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= REPORT_LIMIT)
              $display("%0t: mismatch: expected kind %0d data %02h, got kind %0d data %02h",
                       $realtime, want.kind, want.data,
                       out_mon.done_kind, out_mon.read_data);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(blit_predict(kind_e'(in_mon.kind),
                                                {in_mon.glyph_col4, in_mon.glyph_col3,
                                                 in_mon.glyph_col2, in_mon.glyph_col1,
                                                 in_mon.glyph_col0},
                                                in_mon.x_pos, in_mon.y_pos,
                                                in_mon.scale, in_mon.read_addr));
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/scaled_glyph_page_blitter_test.sv */
`timescale 1ns / 1ps

module scaled_glyph_page_blitter_test;
  import sgpb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned IDLE_PERCENT = 33;
  // Watchdog limit; it leaves wide room for big-scale draws
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  // Linger after the last result to catch strays
  localparam int unsigned DRAIN_CYCLES = STORE_DEPTH + 100;
  localparam int unsigned STEADY_FIRST = 150;
  localparam int unsigned STEADY_LAST  = 230;

  localparam logic [GLYPH_COLS*BYTE_W-1:0] GLYPH_FULL    = {GLYPH_COLS{8'hFF}};
  localparam logic [GLYPH_COLS*BYTE_W-1:0] GLYPH_ROWS7   = {GLYPH_COLS{8'h7F}};
  localparam logic [GLYPH_COLS*BYTE_W-1:0] GLYPH_CHECKER = {8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55};
  localparam logic [GLYPH_COLS*BYTE_W-1:0] GLYPH_TOP_BIT = {GLYPH_COLS{8'h80}};
  localparam logic [GLYPH_COLS*BYTE_W-1:0] GLYPH_DOT     = 40'h01;
  localparam logic [GLYPH_COLS*BYTE_W-1:0] GLYPH_NONE    = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        steady;          // high: neither side idles
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending_count;

  sgpb_in_if  in_if ();
  sgpb_out_if out_if ();

  scaled_glyph_page_blitter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  glyph_blit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: end the run if the block hangs
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("scaled_glyph_page_blitter_test: FAIL");
      $finish;
    end
  end

  // Result side: stall about a third of the cycles, except in the steady window
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Present one transaction at the falling edge and hold it until accepted
  task automatic send_op(input kind_e k, input logic [GLYPH_COLS*BYTE_W-1:0] glyph,
                         input byte_t x, input byte_t y,
                         input logic [SCALE_W-1:0] s, input addr_t a);
    // Insert random idle cycles ahead of the transaction
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= k;
    in_if.glyph_col0 <= glyph[0*BYTE_W +: BYTE_W];
    in_if.glyph_col1 <= glyph[1*BYTE_W +: BYTE_W];
    in_if.glyph_col2 <= glyph[2*BYTE_W +: BYTE_W];
    in_if.glyph_col3 <= glyph[3*BYTE_W +: BYTE_W];
    in_if.glyph_col4 <= glyph[4*BYTE_W +: BYTE_W];
    in_if.x_pos      <= x;
    in_if.y_pos      <= y;
    in_if.scale      <= s;
    in_if.read_addr  <= a;
    // Ready is sampled at the rising edge, before the block updates it
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [GLYPH_COLS*BYTE_W-1:0] glyph;
    int unsigned                  pick;
    int unsigned                  done_items;
    byte_t                        x;
    byte_t                        y;
    logic [SCALE_W-1:0]           s;
    addr_t                        a;

    // Drive every input to a known value from time zero
    rst_ni           = 1'b0;
    steady           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_CLEAR;
    in_if.glyph_col0 = '0;
    in_if.glyph_col1 = '0;
    in_if.glyph_col2 = '0;
    in_if.glyph_col3 = '0;
    in_if.glyph_col4 = '0;
    in_if.x_pos      = '0;
    in_if.y_pos      = '0;
    in_if.scale      = '0;
    in_if.read_addr  = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The block sweeps its store after reset; the handshake
    // holds the first transaction until that sweep is over.
    // Reads right after reset: store must be zero at both ends
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(0));
    send_op(KIND_READ, GLYPH_FULL, 8'hFF, 8'hFF, 4'hF, addr_t'(STORE_DEPTH - 1));
    // Full glyph at the origin, scale 1; bit 7 of each column must be dropped
    send_op(KIND_DRAW, GLYPH_FULL, 8'd0, 8'd0, 4'd1, addr_t'(0));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(0));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(4));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(5));
    // Scale zero draws nothing
    send_op(KIND_DRAW, GLYPH_FULL, 8'd10, 8'd0, 4'd0, addr_t'(0));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(10));
    // Largest scale, clipped at the right edge and the bottom
    send_op(KIND_DRAW, GLYPH_ROWS7, 8'd120, 8'd20, 4'd15, addr_t'(0));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(3*DISP_WIDTH + 127));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(2*DISP_WIDTH + 120));
    // Coordinates near 255 wrap around onto the top-left corner
    send_op(KIND_DRAW, GLYPH_CHECKER, 8'd254, 8'd253, 4'd3, addr_t'(0));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(1));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(DISP_WIDTH + 2));
    // Unused kind with every field at its maximum: no effect, echo kind
    send_op(KIND_UNUSED, GLYPH_FULL, 8'hFF, 8'hFF, 4'hF, addr_t'(STORE_DEPTH - 1));
    send_op(KIND_CLEAR, GLYPH_FULL, 8'hFF, 8'hFF, 4'hF, addr_t'(STORE_DEPTH - 1));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(0));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(2*DISP_WIDTH + 120));
    // Only the ignored top bit set: nothing is drawn
    send_op(KIND_DRAW, GLYPH_TOP_BIT, 8'd0, 8'd0, 4'd2, addr_t'(0));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(0));
    // Origin at 255,255: first column and row fall off, the rest wrap to zero
    send_op(KIND_DRAW, GLYPH_FULL, 8'd255, 8'd255, 4'd1, addr_t'(0));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(0));
    // Single pixel in the bottom-right corner lands in bit 7 of the last byte
    send_op(KIND_DRAW, GLYPH_DOT, 8'(DISP_WIDTH - 1), 8'(DISP_HEIGHT - 1), 4'd1, addr_t'(0));
    send_op(KIND_READ, GLYPH_NONE, 8'd0, 8'd0, 4'd0, addr_t'(STORE_DEPTH - 1));

    // Random part: mostly on-screen draws and reads, with rare clears so the
    // store fills up without saturating; some unused-kind noise on top
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      steady        = (done_items >= STEADY_FIRST && done_items < STEADY_LAST);
      pick          = $urandom_range(99);
      glyph[31:0]   = $urandom();
      glyph[39:32]  = byte_t'($urandom_range(255));
      x             = byte_t'($urandom_range(255));
      y             = byte_t'($urandom_range(255));
      s             = 4'($urandom_range(15));
      a             = addr_t'($urandom_range(STORE_DEPTH - 1));
      if (pick < 5) begin
        send_op(KIND_CLEAR, glyph, x, y, s, a);
      end else if (pick < 8) begin
        // ignored by the block: keep it out of the item count
        send_op(KIND_UNUSED, glyph, x, y, s, a);
        continue;
      end else if (pick < 52) begin
        // Keep most glyphs on screen and most scales small to bound run time
        if ($urandom_range(99) < 85) x = byte_t'($urandom_range(DISP_WIDTH - 1));
        if ($urandom_range(99) < 85) y = byte_t'($urandom_range(DISP_HEIGHT - 1));
        if ($urandom_range(99) < 94) s = 4'($urandom_range(4));
        else                         s = 4'($urandom_range(15, 5));
        send_op(KIND_DRAW, glyph, x, y, s, a);
      end else begin
        send_op(KIND_READ, glyph, x, y, s, a);
      end
      done_items = done_items + 1;
    end
    steady = 1'b0;
    in_if.valid <= 1'b0;

    // Drain: wait for every result, then linger to catch strays
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && pending_count == 0) begin
      $display("scaled_glyph_page_blitter_test: PASS");
    end else begin
      $display("scaled_glyph_page_blitter_test: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sgpb_pkg.sv
rtl/sgpb_if.sv
rtl/scaled_glyph_page_blitter.sv
tb/glyph_blit_checker.sv
tb/scaled_glyph_page_blitter_test.sv
